[sv/crop_window_align_and_scale_core_defines.svh]
// Assertion macros for the crop window core.
// Each use expects clk_i and rst_ni in scope.
`ifndef CROP_WINDOW_ALIGN_AND_SCALE_CORE_DEFINES_SVH
`define CROP_WINDOW_ALIGN_AND_SCALE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CWAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CWAS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CWAS_ASSERT(lbl, prop, msg)
`define CWAS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[sv/cwas_pkg.sv]
package cwas_pkg;

  localparam int unsigned COORD_BITS_DEF = 14;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned BUF_W_RESET = 1920;
  localparam int unsigned BUF_H_RESET = 1080;

  typedef enum logic [1:0] {
    CFG_BUF_W = 2'd0,
    CFG_BUF_H = 2'd1,
    CFG_REF_W = 2'd2,
    CFG_REF_H = 2'd3
  } cfg_idx_e;

endpackage

[sv/crop_window_align_and_scale_core.sv]
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: crop_left, crop_top, crop_width, crop_height; tuser: crop_present
// m_axis    out  tdata: out_left, out_top, out_width, out_height
// cfg       in   cfg_idx_i 0..3: buffer_width, buffer_height, reference_width, reference_height
//
// One item per cycle while the pipeline is not stalled. Most of the pipeline depth
// lies in the three bit-per-stage divider chains (ratio, reference, scale).
// rst_ni clears valids and loads the register reset values.
// All stages share one enable: the pipeline stalls only while the output register is
// full and m_axis_tready is low.
`include "crop_window_align_and_scale_core_defines.svh"

module crop_window_align_and_scale_core #(
  parameter int unsigned COORD_BITS = cwas_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = cwas_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [COORD_BITS-1:0]                cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // crop_left, crop_top, crop_width, crop_height
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // crop_present
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_left, out_top, out_width, out_height
  output logic [((4*COORD_BITS+7)/8)*8-1:0]    m_axis_tdata
);

  import cwas_pkg::*;

  localparam int unsigned C       = COORD_BITS;
  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned TDATA_W = ((4*C+7)/8)*8;
  localparam int unsigned REF_W   = C + 2;
  localparam int unsigned XR_W    = C + F;
  localparam int unsigned NT_W    = C + XR_W;
  localparam int unsigned NUM_W   = C + REF_W;
  localparam int unsigned RR_W    = NUM_W + F;
  localparam int unsigned QW      = 2*C + F + 5;
  localparam int unsigned MAG_W   = QW - 1;
  localparam int unsigned LO_W    = MAG_W / 2;
  localparam int unsigned HI_W    = MAG_W - LO_W;
  localparam int unsigned PROD_W  = MAG_W + C;
  localparam int unsigned XS_W    = PROD_W - F;
  localparam int unsigned SC_W    = C + 1;
  localparam int unsigned L1      = XR_W;
  localparam int unsigned L3      = RR_W;
  localparam int unsigned L4      = SC_W;
  localparam int unsigned TOL_INT = (1 << F) / 100;
  localparam logic [XR_W:0] TOL   = (XR_W+1)'(TOL_INT);

  typedef struct packed {
    logic             zero;
    logic [C-1:0]     cl;
    logic [C-1:0]     ct;
    logic [C-1:0]     cw;
    logic [C-1:0]     ch;
    logic [REF_W-1:0] refw;
    logic [REF_W-1:0] refh;
  } sb1_t;

  typedef struct packed {
    logic             zero;
    logic             trim_h;
    logic             trim_w;
    logic [C-1:0]     cl;
    logic [C-1:0]     ct;
    logic [C-1:0]     cw;
    logic [C-1:0]     ch;
    logic [REF_W-1:0] refw;
    logic [NT_W-1:0]  nt;
    logic [REF_W-1:0] refs;
    logic [C-1:0]     pos;
    logic [C-1:0]     len;
  } sb2_t;

  typedef struct packed {
    logic       zero;
    logic [3:0] sat;
  } sb4_t;

  function automatic logic signed [QW-1:0] to_q(logic [C-1:0] v);
    return $signed({{(QW-C-F){1'b0}}, v, {F{1'b0}}});
  endfunction

  function automatic logic signed [QW-1:0] half_tz(logic signed [QW-1:0] v);
    logic signed [QW-1:0] t;
    t = v + $signed({{(QW-1){1'b0}}, v[QW-1]});
    return t >>> 1;
  endfunction

  function automatic logic [2*C-1:0] clamp_span(logic [SC_W-1:0] p, logic [SC_W-1:0] l,
                                                logic [C-1:0] lim);
    logic [SC_W:0]   sum;
    logic [SC_W-1:0] limx;
    logic [SC_W-1:0] po;
    logic [SC_W-1:0] lo;
    sum  = {1'b0, p} + {1'b0, l};
    limx = SC_W'(lim);
    po   = p;
    lo   = l;
    if (sum > {1'b0, limx}) begin
      if (l <= limx) begin
        po = limx - l;
      end else begin
        po = '0;
        lo = limx;
      end
    end
    return {lo[C-1:0], po[C-1:0]};
  endfunction

  // ---------------- configuration ----------------
  logic [C-1:0] bw_q, bh_q, rw_q, rh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= C'(BUF_W_RESET);
      bh_q <= C'(BUF_H_RESET);
      rw_q <= '0;
      rh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BUF_W: bw_q <= cfg_data_i;
        CFG_BUF_H: bh_q <= cfg_data_i;
        CFG_REF_W: rw_q <= cfg_data_i;
        CFG_REF_H: rh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline ----------------
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  logic a_v_q, b_v_q, c_v_q, e_v_q, f_v_q, g_v_q, h_v_q, i_v_q, j_v_q;
  logic v1_q [L1];
  logic v3_q [L3];
  logic v4_q [L4];

  // stage A: input register
  logic         a_pres_q;
  logic [C-1:0] a_l_q, a_t_q, a_w_q, a_h_q;

  // stage B: select window and reference
  sb1_t b_sb_d, b_sb_q;
  logic [C-1:0] b_cl, b_ct, b_cw, b_ch;
  logic [REF_W-1:0] b_refw, b_refh;

  always_comb begin
    b_cl   = a_pres_q ? a_l_q : '0;
    b_ct   = a_pres_q ? a_t_q : '0;
    b_cw   = a_pres_q ? a_w_q : bw_q;
    b_ch   = a_pres_q ? a_h_q : bh_q;
    b_refw = (rw_q == '0) ? {1'b0, b_cl, 1'b0} + REF_W'(b_cw) : REF_W'(rw_q);
    b_refh = (rw_q == '0) ? {1'b0, b_ct, 1'b0} + REF_W'(b_ch) : REF_W'(rh_q);
    b_sb_d.zero = (bw_q == '0) || (bh_q == '0) || (b_refw == '0);
    b_sb_d.cl   = b_cl;
    b_sb_d.ct   = b_ct;
    b_sb_d.cw   = b_cw;
    b_sb_d.ch   = b_ch;
    b_sb_d.refw = b_refw;
    b_sb_d.refh = b_refh;
  end

  // ratio dividers
  logic [XR_W-1:0] xr, yr;
  sb1_t sb1_q [L1];

  cwas_div #(.NUM_W(XR_W), .DEN_W(C), .QUO_W(XR_W)) u_div_xr (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({b_sb_q.cw, {F{1'b0}}}),
    .den_i (bw_q),
    .quo_o (xr)
  );

  cwas_div #(.NUM_W(XR_W), .DEN_W(C), .QUO_W(XR_W)) u_div_yr (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({b_sb_q.ch, {F{1'b0}}}),
    .den_i (bh_q),
    .quo_o (yr)
  );

  // stage C: aspect compare, trim products
  sb1_t             s1;
  sb2_t             c_sb_d, c_sb_q;
  logic             c_th, c_tw;
  logic [C-1:0]     c_bsel, c_den_d, c_den_q;
  logic [XR_W-1:0]  c_rsel;
  logic [REF_W-1:0] c_refo;
  logic [NUM_W-1:0] c_numr_d, c_numr_q;

  always_comb begin
    s1       = sb1_q[L1-1];
    c_th     = {1'b0, yr} > {1'b0, xr} + TOL;
    c_tw     = !c_th && ({1'b0, xr} > {1'b0, yr} + TOL);
    c_bsel   = c_th ? bh_q : bw_q;
    c_rsel   = c_th ? xr : yr;
    c_refo   = c_th ? s1.refw : s1.refh;
    c_den_d  = c_th ? bw_q : bh_q;
    c_numr_d = NUM_W'(c_bsel) * NUM_W'(c_refo);
    c_sb_d.zero   = s1.zero;
    c_sb_d.trim_h = c_th;
    c_sb_d.trim_w = c_tw;
    c_sb_d.cl     = s1.cl;
    c_sb_d.ct     = s1.ct;
    c_sb_d.cw     = s1.cw;
    c_sb_d.ch     = s1.ch;
    c_sb_d.refw   = s1.refw;
    c_sb_d.nt     = NT_W'(c_bsel) * NT_W'(c_rsel);
    c_sb_d.refs   = c_th ? s1.refh : s1.refw;
    c_sb_d.pos    = c_th ? s1.ct : s1.cl;
    c_sb_d.len    = c_th ? s1.ch : s1.cw;
  end

  // reference divider
  logic [RR_W-1:0] rref;
  sb2_t sb3_q [L3];

  cwas_div #(.NUM_W(RR_W), .DEN_W(C), .QUO_W(RR_W)) u_div_ref (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({c_numr_q, {F{1'b0}}}),
    .den_i (c_den_q),
    .quo_o (rref)
  );

  // stage E: differences
  sb2_t s3, e_sb_q, f_sb_q;
  logic signed [QW-1:0] e_d1_d, e_d2_d, e_d1_q, e_d2_q, f_h1_q, f_h2_q;

  always_comb begin
    s3     = sb3_q[L3-1];
    e_d1_d = $signed({{(QW-REF_W-F){1'b0}}, s3.refs, {F{1'b0}}})
           - $signed({{(QW-RR_W){1'b0}}, rref});
    e_d2_d = to_q(s3.len) - $signed({{(QW-NT_W){1'b0}}, s3.nt});
  end

  // stage G: recentered position, pick Q values (left, top, width, height)
  logic signed [QW-1:0] g_new;
  logic signed [QW-1:0] g_val_d [4];
  logic signed [QW-1:0] g_val_q [4];
  logic                 g_zero_q;
  logic [REF_W-1:0]     g_refw_q;

  always_comb begin
    g_new      = to_q(f_sb_q.pos) + f_h2_q - f_h1_q;
    g_val_d[0] = to_q(f_sb_q.cl);
    g_val_d[1] = to_q(f_sb_q.ct);
    g_val_d[2] = to_q(f_sb_q.cw);
    g_val_d[3] = to_q(f_sb_q.ch);
    if (f_sb_q.trim_h) begin
      g_val_d[1] = g_new;
      g_val_d[3] = $signed({{(QW-NT_W){1'b0}}, f_sb_q.nt});
    end else if (f_sb_q.trim_w) begin
      g_val_d[0] = g_new;
      g_val_d[2] = $signed({{(QW-NT_W){1'b0}}, f_sb_q.nt});
    end
  end

  // stage H: scale partial products
  logic [MAG_W-1:0]     h_mag [4];
  logic [LO_W+C-1:0]    h_plo_d [4];
  logic [LO_W+C-1:0]    h_plo_q [4];
  logic [HI_W+C-1:0]    h_phi_d [4];
  logic [HI_W+C-1:0]    h_phi_q [4];
  logic                 h_zero_q;
  logic [REF_W-1:0]     h_refw_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      h_mag[k]   = (!g_val_q[k][QW-1] && (g_val_q[k] != '0)) ? g_val_q[k][MAG_W-1:0] : '0;
      h_plo_d[k] = (LO_W+C)'(h_mag[k][LO_W-1:0]) * (LO_W+C)'(bw_q);
      h_phi_d[k] = (HI_W+C)'(h_mag[k][MAG_W-1:LO_W]) * (HI_W+C)'(bw_q);
    end
  end

  // stage I: product sum, drop fraction
  logic [PROD_W-1:0] i_prod [4];
  logic [XS_W-1:0]   i_xs_q [4];
  logic              i_zero_q;
  logic [REF_W-1:0]  i_refw_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      i_prod[k] = {h_phi_q[k], {LO_W{1'b0}}} + PROD_W'(h_plo_q[k]);
    end
  end

  // stage J: saturation check
  logic [XS_W-1:0]  j_xs_q [4];
  logic [3:0]       j_sat_d, j_sat_q;
  logic             j_zero_q;
  logic [REF_W-1:0] j_refw_q;
  logic [XS_W-1:0]  j_lim;

  always_comb begin
    j_lim = {{(XS_W-REF_W-SC_W){1'b0}}, i_refw_q, {SC_W{1'b0}}};
    for (int k = 0; k < 4; k++) begin
      j_sat_d[k] = i_xs_q[k] >= j_lim;
    end
  end

  // scale dividers
  logic [SC_W-1:0] sc [4];
  sb4_t sb4_q [L4];
  sb4_t s4;

  for (genvar k = 0; k < 4; k++) begin : g_scale
    cwas_div #(.NUM_W(XS_W), .DEN_W(REF_W), .QUO_W(SC_W)) u_div_sc (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (j_xs_q[k]),
      .den_i (j_refw_q),
      .quo_o (sc[k])
    );
  end

  // stage K: clamp into buffer
  logic [SC_W-1:0] k_s [4];
  logic [2*C-1:0]  k_x, k_y;

  always_comb begin
    s4 = sb4_q[L4-1];
    for (int k = 0; k < 4; k++) begin
      k_s[k] = s4.sat[k] ? '1 : sc[k];
    end
    k_x = clamp_span(k_s[0], k_s[2], bw_q);
    k_y = clamp_span(k_s[1], k_s[3], bh_q);
  end

  logic [C-1:0] out_l_q, out_t_q, out_w_q, out_h_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      c_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
      f_v_q       <= 1'b0;
      g_v_q       <= 1'b0;
      h_v_q       <= 1'b0;
      i_v_q       <= 1'b0;
      j_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < L1; i++) v1_q[i] <= 1'b0;
      for (int i = 0; i < L3; i++) v3_q[i] <= 1'b0;
      for (int i = 0; i < L4; i++) v4_q[i] <= 1'b0;
    end else if (en) begin
      a_v_q   <= s_axis_tvalid;
      b_v_q   <= a_v_q;
      v1_q[0] <= b_v_q;
      for (int i = 1; i < L1; i++) v1_q[i] <= v1_q[i-1];
      c_v_q   <= v1_q[L1-1];
      v3_q[0] <= c_v_q;
      for (int i = 1; i < L3; i++) v3_q[i] <= v3_q[i-1];
      e_v_q   <= v3_q[L3-1];
      f_v_q   <= e_v_q;
      g_v_q   <= f_v_q;
      h_v_q   <= g_v_q;
      i_v_q   <= h_v_q;
      j_v_q   <= i_v_q;
      v4_q[0] <= j_v_q;
      for (int i = 1; i < L4; i++) v4_q[i] <= v4_q[i-1];
      out_valid_q <= v4_q[L4-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_pres_q <= s_axis_tuser[0];
      a_l_q    <= s_axis_tdata[C-1:0];
      a_t_q    <= s_axis_tdata[2*C-1:C];
      a_w_q    <= s_axis_tdata[3*C-1:2*C];
      a_h_q    <= s_axis_tdata[4*C-1:3*C];

      b_sb_q   <= b_sb_d;
      sb1_q[0] <= b_sb_q;
      for (int i = 1; i < L1; i++) sb1_q[i] <= sb1_q[i-1];

      c_sb_q   <= c_sb_d;
      c_numr_q <= c_numr_d;
      c_den_q  <= c_den_d;
      sb3_q[0] <= c_sb_q;
      for (int i = 1; i < L3; i++) sb3_q[i] <= sb3_q[i-1];

      e_sb_q <= s3;
      e_d1_q <= e_d1_d;
      e_d2_q <= e_d2_d;

      f_sb_q <= e_sb_q;
      f_h1_q <= half_tz(e_d1_q);
      f_h2_q <= half_tz(e_d2_q);

      g_zero_q <= f_sb_q.zero;
      g_refw_q <= f_sb_q.refw;
      h_zero_q <= g_zero_q;
      h_refw_q <= g_refw_q;
      i_zero_q <= h_zero_q;
      i_refw_q <= h_refw_q;
      j_zero_q <= i_zero_q;
      j_refw_q <= i_refw_q;
      j_sat_q  <= j_sat_d;
      for (int k = 0; k < 4; k++) begin
        g_val_q[k] <= g_val_d[k];
        h_plo_q[k] <= h_plo_d[k];
        h_phi_q[k] <= h_phi_d[k];
        i_xs_q[k]  <= i_prod[k][PROD_W-1:F];
        j_xs_q[k]  <= i_xs_q[k];
      end

      sb4_q[0].zero <= j_zero_q;
      sb4_q[0].sat  <= j_sat_q;
      for (int i = 1; i < L4; i++) sb4_q[i] <= sb4_q[i-1];

      out_l_q <= s4.zero ? '0 : k_x[C-1:0];
      out_w_q <= s4.zero ? '0 : k_x[2*C-1:C];
      out_t_q <= s4.zero ? '0 : k_y[C-1:0];
      out_h_q <= s4.zero ? '0 : k_y[2*C-1:C];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_h_q, out_w_q, out_t_q, out_l_q});

  `CWAS_ASSERT(a_load_on_accept, (s_axis_tvalid && s_axis_tready) |=> a_v_q, "accepted item not in stage A")
  `CWAS_ASSERT(tail_holds_on_stall, (!en && v4_q[L4-1]) |=> v4_q[L4-1], "pipeline tail lost on stall")
  `CWAS_ASSERT_NEVER(trim_exclusive, c_v_q && c_sb_q.trim_h && c_sb_q.trim_w, "both axes trimmed")

endmodule

[sv/cwas_div.sv]
module cwas_div #(
  parameter int unsigned NUM_W = 30,
  parameter int unsigned DEN_W = 14,
  parameter int unsigned QUO_W = 30
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  // restoring divider, one quotient bit per stage, MSB first
  localparam int unsigned RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [RW-1:0]    rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  logic [RW-1:0]    rin [QUO_W];
  logic [RW-1:0]    sub [QUO_W];
  logic [RW-1:0]    rnx [QUO_W];
  logic [DEN_W-1:0] din [QUO_W];
  logic [QUO_W-1:0] qin [QUO_W];
  logic [QUO_W-1:0] qnx [QUO_W];
  logic             ge  [QUO_W];

  always_comb begin
    rin[0] = RW'(num_i);
    din[0] = den_i;
    qin[0] = '0;
    for (int k = 1; k < QUO_W; k++) begin
      rin[k] = rem_q[k-1];
      din[k] = den_q[k-1];
      qin[k] = quo_q[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      sub[k] = RW'(din[k]) << (QUO_W - 1 - k);
      ge[k]  = rin[k] >= sub[k];
      rnx[k] = ge[k] ? rin[k] - sub[k] : rin[k];
      qnx[k] = qin[k];
      qnx[k][QUO_W-1-k] = ge[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUO_W - 1; k++) begin
        rem_q[k] <= rnx[k];
        den_q[k] <= din[k];
      end
      for (int k = 0; k < QUO_W; k++) begin
        quo_q[k] <= qnx[k];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

[dv/tb_crop_window_align_and_scale_core.sv]
`timescale 1ns / 1ps

module tb_crop_window_align_and_scale_core;
  import cwas_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = ((4 * CB + 7) / 8) * 8;
  localparam int LATENCY = 4 * CB + 2 * FB + 13;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint TOL = (64'd1 << FB) / 100;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
  } window_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  coord_t cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata;  // crop_left, crop_top, crop_width, crop_height
  logic [0:0] s_axis_tuser;     // crop_present
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DW-1:0] m_axis_tdata;  // out_left, out_top, out_width, out_height

  crop_window_align_and_scale_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // shadow registers
  longint unsigned buf_w, buf_h, ref_w_reg, ref_h_reg;

  window_t expected_windows[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned scale_to_buffer(longint q, longint unsigned bw,
                                                      longint unsigned rw);
    if (q <= 0) return 0;
    return (longint'(q) * bw) / (rw << FB);
  endfunction

  function automatic window_t predict_window(logic present, coord_t l, coord_t t,
                                             coord_t w, coord_t h);
    window_t r;
    longint unsigned cl, ct, cw, ch, rw, rh, ol, ot, ow, oh;
    longint xr, yr, ql, qt, qw, qh, nspan, rref, delta;
    r = '0;
    if (buf_w == 0 || buf_h == 0) return r;
    if (present) begin
      cl = l; ct = t; cw = w; ch = h;
    end else begin
      cl = 0; ct = 0; cw = buf_w; ch = buf_h;
    end
    if (ref_w_reg == 0) begin
      rw = 2 * cl + cw;
      rh = 2 * ct + ch;
    end else begin
      rw = ref_w_reg;
      rh = ref_h_reg;
    end
    if (rw == 0) return r;
    xr = (cw << FB) / buf_w;
    yr = (ch << FB) / buf_h;
    ql = cl << FB; qt = ct << FB; qw = cw << FB; qh = ch << FB;
    if (yr > xr + TOL) begin
      nspan = longint'(buf_h) * xr;
      rref = ((buf_h * rw) << FB) / buf_w;
      delta = (longint'(rh << FB) - rref) / 2;
      qt = longint'(ct << FB) + (qh - nspan) / 2 - delta;
      qh = nspan;
    end else if (xr > yr + TOL) begin
      nspan = longint'(buf_w) * yr;
      rref = ((buf_w * rh) << FB) / buf_h;
      delta = (longint'(rw << FB) - rref) / 2;
      ql = longint'(cl << FB) + (qw - nspan) / 2 - delta;
      qw = nspan;
    end
    ow = scale_to_buffer(qw, buf_w, rw);
    ol = scale_to_buffer(ql, buf_w, rw);
    oh = scale_to_buffer(qh, buf_w, rw);
    ot = scale_to_buffer(qt, buf_w, rw);
    if (ol + ow > buf_w) begin
      if (ow <= buf_w) ol = buf_w - ow;
      else begin
        ol = 0; ow = buf_w;
      end
    end
    if (ot + oh > buf_h) begin
      if (oh <= buf_h) ot = buf_h - oh;
      else begin
        ot = 0; oh = buf_h;
      end
    end
    r.left = ol[CB-1:0];
    r.top = ot[CB-1:0];
    r.width = ow[CB-1:0];
    r.height = oh[CB-1:0];
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, coord_t val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_BUF_W: buf_w = val;
      CFG_BUF_H: buf_h = val;
      CFG_REF_W: ref_w_reg = val;
      CFG_REF_H: ref_h_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(coord_t bw, coord_t bh, coord_t rw, coord_t rh);
    write_reg(CFG_BUF_W, bw);
    write_reg(CFG_BUF_H, bh);
    write_reg(CFG_REF_W, rw);
    write_reg(CFG_REF_H, rh);
  endtask

  task automatic send_crop(logic present, coord_t l, coord_t t, coord_t w, coord_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = present;
    s_axis_tdata = '0;
    s_axis_tdata[4*CB-1:0] = {h, w, t, l};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_windows.push_back(predict_window(present, l, t, w, h));
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    window_t got, exp_w;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_crop_window_align_and_scale_core: done, errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.left = m_axis_tdata[CB-1:0];
      got.top = m_axis_tdata[2*CB-1:CB];
      got.width = m_axis_tdata[3*CB-1:2*CB];
      got.height = m_axis_tdata[4*CB-1:3*CB];
      if (expected_windows.size() == 0) begin
        $error("unexpected item %h", m_axis_tdata);
        err_count++;
      end else begin
        exp_w = expected_windows.pop_front();
        if (got.left !== exp_w.left) begin
          $error("out_left exp %0d got %0d", exp_w.left, got.left); err_count++;
        end
        if (got.top !== exp_w.top) begin
          $error("out_top exp %0d got %0d", exp_w.top, got.top); err_count++;
        end
        if (got.width !== exp_w.width) begin
          $error("out_width exp %0d got %0d", exp_w.width, got.width); err_count++;
        end
        if (got.height !== exp_w.height) begin
          $error("out_height exp %0d got %0d", exp_w.height, got.height); err_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults;
    send_crop(1'b0, 0, 0, 0, 0);
    send_crop(1'b1, 100, 50, 1720, 980);
    send_crop(1'b1, 0, 0, 1920, 1080);
    drain();
  endtask

  task automatic test_directed;
    set_geometry(1920, 1080, 4000, 3000);
    send_crop(1'b0, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    send_crop(1'b1, 0, 0, 4000, 3000);       // height trim
    send_crop(1'b1, 0, 0, 4000, 1000);       // width trim
    send_crop(1'b1, 0, 0, 1920, 1086);       // within tolerance
    send_crop(1'b1, 0, 0, 1920, 1092);       // just past tolerance
    send_crop(1'b1, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    send_crop(1'b1, 0, 0, 0, 0);
    send_crop(1'b1, 3000, 2000, 2000, 2000); // clamp overrun
    drain();
    set_geometry(1920, 1080, 0, 0);
    send_crop(1'b1, 0, 0, 0, 5);             // derived reference width zero
    send_crop(1'b1, 10, 10, 0, 0);
    send_crop(1'b1, 14'h3fff, 0, 14'h3fff, 1);
    send_crop(1'b1, 0, 14'h3fff, 1, 14'h3fff);
    drain();
    set_geometry(0, 1080, 100, 100);         // zero buffer width
    send_crop(1'b1, 1, 2, 3, 4);
    drain();
    set_geometry(1, 0, 100, 100);            // zero buffer height
    send_crop(1'b0, 1, 2, 3, 4);
    drain();
    set_geometry(1, 1, 14'h3fff, 14'h3fff);
    send_crop(1'b1, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
    send_crop(1'b1, 0, 0, 1, 1);
    drain();
    set_geometry(14'h3fff, 14'h3fff, 1, 0);
    send_crop(1'b1, 0, 0, 1, 1);
    send_crop(1'b0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic send_random_crop;
    coord_t l, t, w, h;
    int unsigned rw, rh;
    if ($urandom_range(99) < 25) begin
      send_crop(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
    end else begin
      rw = (ref_w_reg != 0) ? 32'(ref_w_reg) : 64 + $urandom_range(8000);
      rh = (ref_h_reg != 0) ? 32'(ref_h_reg) : 64 + $urandom_range(6000);
      w = coord_t'(1 + $urandom_range(rw));
      h = ($urandom_range(2) == 0)
          ? coord_t'(longint'(w) * buf_h / (buf_w == 0 ? 1 : buf_w))
          : coord_t'(1 + $urandom_range(rh));
      if (h == 0) h = 1;
      l = (rw > w) ? coord_t'($urandom_range(rw - w)) : '0;
      t = (rh > h) ? coord_t'($urandom_range(rh - h)) : '0;
      send_crop($urandom_range(99) < 92, l, t, w, h);
    end
  endtask

  task automatic test_random(int items);
    coord_t rw;
    for (int cfg_set = 0; cfg_set < 4; cfg_set++) begin
      rw = ($urandom_range(1) == 0) ? '0 : coord_t'(16 + $urandom_range(16000));
      set_geometry(coord_t'(1 + $urandom_range(16382)), coord_t'(1 + $urandom_range(16382)),
                   rw,
                   ($urandom_range(9) == 0) ? '0 : coord_t'(16 + $urandom_range(16000)));
      for (int phase = 0; phase < 4; phase++) begin
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
          default: begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
        for (int i = 0; i < items / 16; i++) send_random_crop();
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure;
    set_geometry(1920, 1080, 0, 0);
    @(negedge clk_i);
    hold_cycles = 3 * LATENCY;
    for (int i = 0; i < 150; i++) send_random_crop();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BUF_W;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    buf_w = BUF_W_RESET;
    buf_h = BUF_H_RESET;
    ref_w_reg = 0;
    ref_h_reg = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random(1200);
    drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_count == 0 && expected_windows.size() == 0) begin
      $display("tb_crop_window_align_and_scale_core: done, clean");
    end else begin
      $display("tb_crop_window_align_and_scale_core: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/cwas_pkg.sv
sv/cwas_div.sv
sv/crop_window_align_and_scale_core.sv
dv/tb_crop_window_align_and_scale_core.sv
